>>> sv/sensor_frame_sync_checksum_parser_unit_macros.svh
// Assertion macros for the sensor frame parser
`ifndef SENSOR_FRAME_SYNC_CHECKSUM_PARSER_UNIT_MACROS_SVH
`define SENSOR_FRAME_SYNC_CHECKSUM_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define SFSCP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfscp assertion failed");

// next-cycle implication
`define SFSCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfscp assertion failed");

`endif

>>> sv/sfscp_pkg.sv
// Types and constants shared by the sensor frame parser
package sfscp_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;

  typedef struct packed {
    logic [WORD_W-1:0] hcho_hundredths;
    logic [WORD_W-1:0] co2_ppm;
  } result_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic head_valid;
    logic skid_valid;
  } buf_status_t;

endpackage

>>> sv/sfscp_if.sv
// Valid/ready channel interfaces for received bytes and parsed results
interface sfscp_rx_if;
  logic                         valid;
  logic                         ready;
  logic [sfscp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfscp_res_if;
  logic                         valid;
  logic                         ready;
  logic [sfscp_pkg::WORD_W-1:0] hcho_hundredths;
  logic [sfscp_pkg::WORD_W-1:0] co2_ppm;

  modport source (output valid, output hcho_hundredths, output co2_ppm, input ready);
  modport sink (input valid, input hcho_hundredths, input co2_ppm, output ready);
endinterface

>>> sv/sensor_frame_sync_checksum_parser_unit.sv
// Top level of the header-synchronized additive-checksum frame parser
//
//   channel  dir  transfer            payload
//   rx       in   rx.valid & ready    rx_byte[7:0]
//   res      out  res.valid & ready   hcho_hundredths[15:0], co2_ppm[15:0]
//   cfg      in   cfg_we              cfg_wdata[7:0] -> header_byte
//
// One byte per cycle while rx.ready is high; frame test and result capture
// happen at the byte's transfer edge, and the result is on res the next
// cycle unless an older result waits there, else it holds in the skid slot.
// The window is a chain of FRAME_LEN-1 cells that shift on each transfer; a
// running sum of the occupied cells gives the checksum.
// rx.ready drops only while the skid slot holds a second result.
// Synchronous reset empties the window and sets header_byte to 0xAA.
module sensor_frame_sync_checksum_parser_unit #(
  parameter int FRAME_LEN = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  sfscp_rx_if.sink                     rx,
  sfscp_res_if.source                  res,
  input  logic                         cfg_we,
  input  logic [sfscp_pkg::BYTE_W-1:0] cfg_wdata
);

  `include "sensor_frame_sync_checksum_parser_unit_macros.svh"

  logic [sfscp_pkg::BYTE_W-1:0] header_byte;
  logic [sfscp_pkg::BYTE_W-1:0] psum;
  logic [sfscp_pkg::BYTE_W-1:0] psum_next;
  logic [sfscp_pkg::BYTE_W-1:0] cell_byte [FRAME_LEN-1];
  logic [FRAME_LEN-2:0]         cell_valid;
  logic [sfscp_pkg::BYTE_W-1:0] leaving;
  logic                         xfer;
  logic                         hit;
  sfscp_pkg::cell_ctrl_t        ctrl;
  sfscp_pkg::result_t           result;
  sfscp_pkg::buf_status_t       status;

  assign rx.ready = !status.skid_valid;
  assign xfer     = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= sfscp_pkg::HEADER_RESET;
    end else if (cfg_we) begin
      header_byte <= cfg_wdata;
    end
  end

  assign hit = xfer && (&cell_valid) && (cell_byte[0] == header_byte)
               && (psum == rx.rx_byte);

  assign ctrl.shift = xfer;
  assign ctrl.clear = hit;

  for (genvar i = 0; i < FRAME_LEN - 1; i++) begin : g_cell
    if (i == FRAME_LEN - 2) begin : g_last
      sfscp_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .data_in   (rx.rx_byte),
        .valid_in  (1'b1),
        .data_out  (cell_byte[i]),
        .valid_out (cell_valid[i])
      );
    end else begin : g_mid
      sfscp_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .data_in   (cell_byte[i+1]),
        .valid_in  (cell_valid[i+1]),
        .data_out  (cell_byte[i]),
        .valid_out (cell_valid[i])
      );
    end
  end

  assign leaving = cell_valid[0] ? cell_byte[0] : '0;

  always_comb begin
    psum_next = psum;
    if (xfer) begin
      psum_next = hit ? '0 : psum - leaving + rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      psum <= '0;
    end else begin
      psum <= psum_next;
    end
  end

  assign result.hcho_hundredths = {cell_byte[3], cell_byte[2]};
  assign result.co2_ppm         = {cell_byte[5], cell_byte[4]};

  sfscp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (hit),
    .push_data (result),
    .res       (res),
    .status    (status)
  );

  `SFSCP_ASSERT_SAME(a_skid_behind_head, status.skid_valid, status.head_valid)
  `SFSCP_ASSERT_NEXT(a_hit_shows_result, hit, res.valid)
  `SFSCP_ASSERT_NEXT(a_hit_empties_window, hit, (cell_valid == '0) && (psum == '0))

endmodule

>>> sv/sfscp_cell.sv
// One window cell: a byte and its occupied flag, shifted toward the oldest end
module sfscp_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  sfscp_pkg::cell_ctrl_t        ctrl,
  input  logic [sfscp_pkg::BYTE_W-1:0] data_in,
  input  logic                         valid_in,
  output logic [sfscp_pkg::BYTE_W-1:0] data_out,
  output logic                         valid_out
);

  logic [sfscp_pkg::BYTE_W-1:0] data;
  logic                         valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= valid_in && !ctrl.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= data_in;
    end
  end

  assign data_out  = data;
  assign valid_out = valid;

endmodule

>>> sv/sfscp_out_buf.sv
// Result output register with one skid slot
module sfscp_out_buf (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  sfscp_pkg::result_t      push_data,
  sfscp_res_if.source             res,
  output sfscp_pkg::buf_status_t  status
);

  sfscp_pkg::result_t head;
  sfscp_pkg::result_t skid;
  logic               head_valid;
  logic               skid_valid;
  logic               head_free;

  assign head_free = !head_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (head_free) begin
      head_valid <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      head <= skid_valid ? skid : push_data;
      if (skid_valid && push) begin
        skid <= push_data;
      end
    end else if (push) begin
      skid <= push_data;
    end
  end

  assign res.valid           = head_valid;
  assign res.hcho_hundredths = head.hcho_hundredths;
  assign res.co2_ppm         = head.co2_ppm;
  assign status.head_valid   = head_valid;
  assign status.skid_valid   = skid_valid;

endmodule

>>> test/sfscp_reading_check.sv
// Checker for the sensor frame parser: predicts readings from byte transfers and compares them
module sfscp_reading_check #(
  parameter int FRAME_LEN = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  sfscp_rx_if                          rx,
  sfscp_res_if                         res,
  input  logic                         cfg_we,
  input  logic [sfscp_pkg::BYTE_W-1:0] cfg_wdata,
  output int                           mismatches,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [sfscp_pkg::BYTE_W-1:0] header;
  logic [sfscp_pkg::BYTE_W-1:0] win [FRAME_LEN];
  int                           fill;
  sfscp_pkg::result_t           readings_q [$];

  task automatic note_mismatch(input string field, input logic [sfscp_pkg::WORD_W-1:0] want,
                               input logic [sfscp_pkg::WORD_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $realtime, field, want, got);
    end
  endtask

  task automatic absorb_byte(input logic [sfscp_pkg::BYTE_W-1:0] b);
    logic [sfscp_pkg::BYTE_W-1:0] sum;
    sfscp_pkg::result_t           r;
    if (fill < FRAME_LEN) begin
      win[fill] = b;
      fill++;
    end else begin
      for (int i = 0; i < FRAME_LEN - 1; i++) win[i] = win[i+1];
      win[FRAME_LEN-1] = b;
    end
    if (fill == FRAME_LEN && win[0] == header) begin
      sum = '0;
      for (int i = 0; i < FRAME_LEN - 1; i++) sum += win[i];
      if (sum == win[FRAME_LEN-1]) begin
        r.hcho_hundredths = {win[3], win[2]};
        r.co2_ppm         = {win[5], win[4]};
        readings_q.push_back(r);
        fill = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    sfscp_pkg::result_t want;
    if (rst) begin
      header = sfscp_pkg::HEADER_RESET;
      fill   = 0;
      readings_q.delete();
    end else begin
      if (cfg_we) header = cfg_wdata;
      if (res.valid && res.ready) begin
        if (readings_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected reading hcho_hundredths=%h co2_ppm=%h",
                     $realtime, res.hcho_hundredths, res.co2_ppm);
          end
        end else begin
          want = readings_q.pop_front();
          if (res.hcho_hundredths !== want.hcho_hundredths) begin
            note_mismatch("hcho_hundredths", want.hcho_hundredths, res.hcho_hundredths);
          end
          if (res.co2_ppm !== want.co2_ppm) begin
            note_mismatch("co2_ppm", want.co2_ppm, res.co2_ppm);
          end
        end
      end
      if (rx.valid && rx.ready) absorb_byte(rx.rx_byte);
    end
    pending = readings_q.size();
  end
endmodule

>>> test/sensor_frame_sync_checksum_parser_unit_test.sv
// Testbench top for the sensor frame parser: byte stimulus, result back-pressure and verdict
module sensor_frame_sync_checksum_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_LEN   = 9;
  localparam int PHASE_BYTES = 75;
  localparam int NUM_PHASES  = 6;

  typedef logic [sfscp_pkg::BYTE_W-1:0] byte_t;
  typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  logic  clk;
  logic  rst;
  logic  cfg_we;
  byte_t cfg_wdata;
  int    mismatches;
  int    pending_readings;
  bit    calm;
  int    bytes_sent;

  sfscp_rx_if  rx_ch ();
  sfscp_res_if res_ch ();

  sensor_frame_sync_checksum_parser_unit #(
    .FRAME_LEN(FRAME_LEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx_ch),
    .res      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  sfscp_reading_check #(
    .FRAME_LEN(FRAME_LEN)
  ) reading_check (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .pending   (pending_readings)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic byte_t random_data();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return byte_t'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input byte_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_ch.valid   = 1'b1;
    rx_ch.rx_byte = b;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input byte_t hdr, input fill_t fill, input bit corrupt);
    byte_t frm [FRAME_LEN];
    byte_t sum;
    frm[0] = hdr;
    sum    = hdr;
    for (int i = 1; i < FRAME_LEN - 1; i++) begin
      case (fill)
        FILL_ONES:  frm[i] = 8'hFF;
        FILL_ZEROS: frm[i] = 8'h00;
        default:    frm[i] = random_data();
      endcase
      sum += frm[i];
    end
    frm[FRAME_LEN-1] = corrupt ? sum ^ byte_t'($urandom_range(1, 255)) : sum;
    foreach (frm[i]) send_byte(frm[i]);
  endtask

  task automatic drain();
    rx_ch.valid = 1'b0;
    while (pending_readings != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_header(input byte_t v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    res_ch.ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
        res_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin
    byte_t hdr;
    int    phase_start;
    int    r;
    int    n;
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    calm          = 1'b0;
    bytes_sent    = 0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // checksum wraps with all-ones payload at the reset header
    send_frame(sfscp_pkg::HEADER_RESET, FILL_ONES, 1'b0);
    drain();
    write_header(8'h00);
    // junk byte fills the window first, then the frame slides into place
    send_byte(8'h33);
    send_frame(8'h00, FILL_ZEROS, 1'b0);
    send_frame(8'h00, FILL_RANDOM, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       hdr = sfscp_pkg::HEADER_RESET;
        1:       hdr = 8'hFF;
        3:       hdr = 8'h00;
        default: hdr = byte_t'($urandom_range(0, 255));
      endcase
      drain();
      write_header(hdr);
      calm        = (p == 2);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          send_frame(hdr, FILL_RANDOM, 1'b0);
        end else if (r < 78) begin
          send_frame(hdr, FILL_RANDOM, 1'b1);
        end else if (r < 90) begin
          n = $urandom_range(1, 5);
          repeat (n) send_byte(($urandom_range(0, 3) == 0) ? hdr : random_data());
        end else begin
          n = $urandom_range(1, FRAME_LEN - 2);
          send_byte(hdr);
          repeat (n) send_byte(random_data());
        end
      end
    end
    calm = 1'b0;
    drain();

    if (mismatches == 0 && pending_readings == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
